### rtl/core/lllt_pkg.sv
// shared types and constants for the locker lock and light timer unit
package lllt_pkg;

  // command codes carried in the mode field
  localparam logic [2:0] MODE_TICK        = 3'd0;
  localparam logic [2:0] MODE_OPEN_DOOR   = 3'd1;
  localparam logic [2:0] MODE_OPEN_LIGHT  = 3'd2;
  localparam logic [2:0] MODE_CLOSE_LIGHT = 3'd3;
  localparam logic [2:0] MODE_SET_REMAP   = 3'd4;
  localparam logic [2:0] MODE_RESET_REMAP = 3'd5;
  localparam logic [2:0] MODE_QUERY       = 3'd6;

  // configuration register indexes
  localparam logic CFG_LOCK_TICKS  = 1'b0;
  localparam logic CFG_LIGHT_TICKS = 1'b1;

  // register reset values and limits
  localparam logic [7:0]  LOCK_TICKS_RST  = 8'd10;
  localparam logic [11:0] LIGHT_TICKS_RST = 12'd200;
  localparam logic [11:0] LIGHT_MAX       = 12'hfff;

  // highest physical slot that still has bits in the drive word
  localparam int unsigned DRIVE_SLOTS = 16;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] box;
    logic [7:0] remap_slot;
  } in_item_t;

  typedef struct packed {
    logic [31:0] drive_bits;
    logic        light_on;
    logic        rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_ACT,
    ST_LIGHT,
    ST_DONE
  } state_t;

endpackage

### rtl/core/locker_lock_light_timer_unit.sv
// locker lock and light timer unit: per-box one-shot timers with slot remapping
//
// One command is taken at a time. A tick or a remap reset walks every box through one
// shared count/compare/drive-update unit, one box per cycle, then reads back the light
// bit of the addressed box. An accepted door, light or remap command passes through an
// update, then a light read-back; a query, the spare mode code or a rejected command skips
// the update and goes straight to the light read-back. The result stays until it is taken, and a new command is
// taken in the cycle after the result transfer. Configuration writes are taken at any time
// and must only be issued while no command is in progress.
module locker_lock_light_timer_unit #(
  parameter int BOX_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lllt_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lllt_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data
);

  localparam int IDX_W  = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
  localparam int SLOT_W = $clog2(BOX_COUNT + 1);

  // state
  lllt_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  bi_r;
  logic [2:0]        mode_r;
  logic [SLOT_W-1:0] slot_r;
  logic              box_ok_r;
  logic              rej_r;
  logic              light_on_r, light_on_nxt;
  logic [31:0]       drive_r, drive_nxt;
  logic [7:0]        lock_ticks_r;
  logic [11:0]       light_ticks_r;

  logic [8:0]        lock_cnt_r  [BOX_COUNT];
  logic [11:0]       light_cnt_r [BOX_COUNT];
  logic [SLOT_W-1:0] slot_map_r  [BOX_COUNT];

  // array write port, one entry per cycle at idx_r
  logic              lock_we, light_we, map_we;
  logic [8:0]        lock_wd;
  logic [11:0]       light_wd;
  logic [SLOT_W-1:0] map_wd;

  // input decode
  logic              in_xfer;
  logic              box_ok, slot_ok, rej;
  logic [7:0]        box_m1;

  // shared unit: current entry, its slot and drive masks
  logic [8:0]        cur_lock;
  logic [11:0]       cur_light;
  logic [5:0]        cur_slot, slot_m1;
  logic              slot_hit;
  logic [4:0]        lock_pos, light_pos;
  logic [31:0]       lock_mask, light_mask;
  logic [12:0]       light_sum;
  logic [11:0]       light_load;
  logic              last_idx;

  assign in_ready  = (state_r == lllt_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (state_r == lllt_pkg::ST_DONE);
  assign cfg_ready = 1'b1;

  assign out_data.drive_bits = drive_r;
  assign out_data.light_on   = light_on_r;
  assign out_data.rejected   = rej_r;

  // range checks on the incoming command
  assign box_m1  = in_data.box - 8'd1;
  assign box_ok  = (in_data.box != 8'd0) && (9'(in_data.box) <= 9'(BOX_COUNT));
  assign slot_ok = (in_data.remap_slot != 8'd0) &&
                   (9'(in_data.remap_slot) <= 9'(BOX_COUNT));

  always_comb begin
    case (in_data.mode)
      lllt_pkg::MODE_TICK,
      lllt_pkg::MODE_RESET_REMAP: rej = 1'b0;
      lllt_pkg::MODE_SET_REMAP:   rej = !box_ok || !slot_ok;
      default:                    rej = !box_ok;
    endcase
  end

  // slot lookup and bit masks for the addressed entry
  assign cur_lock   = lock_cnt_r[idx_r];
  assign cur_light  = light_cnt_r[idx_r];
  assign cur_slot   = 6'(slot_map_r[idx_r]);
  assign slot_m1    = cur_slot - 6'd1;
  assign slot_hit   = (cur_slot != 6'd0) && (cur_slot <= 6'(lllt_pkg::DRIVE_SLOTS));
  assign lock_pos   = {slot_m1[3:0], 1'b0};
  assign light_pos  = {slot_m1[3:0], 1'b1};
  assign lock_mask  = slot_hit ? (32'd1 << lock_pos)  : 32'd0;
  assign light_mask = slot_hit ? (32'd1 << light_pos) : 32'd0;
  assign last_idx   = (idx_r == IDX_W'(BOX_COUNT - 1));

  // light load saturates at the counter maximum
  assign light_sum  = 13'(light_ticks_r) + 13'd1;
  assign light_load = (light_sum > 13'(lllt_pkg::LIGHT_MAX)) ? lllt_pkg::LIGHT_MAX
                                                              : light_sum[11:0];

  // sequencer: next state, array writes and drive word update
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    drive_nxt    = drive_r;
    light_on_nxt = light_on_r;
    lock_we      = 1'b0;
    light_we     = 1'b0;
    map_we       = 1'b0;
    lock_wd      = cur_lock;
    light_wd     = cur_light;
    map_wd       = SLOT_W'(idx_r) + SLOT_W'(1);
    case (state_r)
      lllt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.mode)
            lllt_pkg::MODE_TICK,
            lllt_pkg::MODE_RESET_REMAP: begin
              idx_nxt   = '0;
              state_nxt = lllt_pkg::ST_WALK;
            end
            lllt_pkg::MODE_OPEN_DOOR,
            lllt_pkg::MODE_OPEN_LIGHT,
            lllt_pkg::MODE_CLOSE_LIGHT,
            lllt_pkg::MODE_SET_REMAP: begin
              idx_nxt   = box_ok ? box_m1[IDX_W-1:0] : '0;
              state_nxt = rej ? lllt_pkg::ST_LIGHT : lllt_pkg::ST_ACT;
            end
            default: begin
              idx_nxt   = box_ok ? box_m1[IDX_W-1:0] : '0;
              state_nxt = lllt_pkg::ST_LIGHT;
            end
          endcase
        end
      end
      lllt_pkg::ST_WALK: begin
        if (mode_r == lllt_pkg::MODE_RESET_REMAP) begin
          map_we = 1'b1;
        end else begin
          // expiring counts release their output, then all nonzero counts drop
          if (cur_lock == 9'd1) begin
            drive_nxt = drive_nxt & ~lock_mask;
          end
          if (cur_light == 12'd1) begin
            drive_nxt = drive_nxt & ~light_mask;
          end
          lock_we  = (cur_lock != 9'd0);
          lock_wd  = cur_lock - 9'd1;
          light_we = (cur_light != 12'd0);
          light_wd = cur_light - 12'd1;
        end
        if (last_idx) begin
          idx_nxt   = bi_r;
          state_nxt = lllt_pkg::ST_LIGHT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      lllt_pkg::ST_ACT: begin
        case (mode_r)
          lllt_pkg::MODE_OPEN_DOOR: begin
            lock_we   = 1'b1;
            lock_wd   = 9'(lock_ticks_r) + 9'd1;
            light_we  = 1'b1;
            light_wd  = light_load;
            drive_nxt = drive_r | lock_mask | light_mask;
          end
          lllt_pkg::MODE_OPEN_LIGHT: begin
            light_we  = 1'b1;
            light_wd  = light_load;
            drive_nxt = drive_r | light_mask;
          end
          lllt_pkg::MODE_CLOSE_LIGHT: begin
            light_we  = 1'b1;
            light_wd  = 12'd0;
            drive_nxt = drive_r & ~light_mask;
          end
          lllt_pkg::MODE_SET_REMAP: begin
            map_we = 1'b1;
            map_wd = slot_r;
          end
          default: begin
          end
        endcase
        state_nxt = lllt_pkg::ST_LIGHT;
      end
      lllt_pkg::ST_LIGHT: begin
        // read back the light bit of the addressed box after the update
        light_on_nxt = box_ok_r && slot_hit && drive_r[light_pos];
        state_nxt    = lllt_pkg::ST_DONE;
      end
      lllt_pkg::ST_DONE: begin
        if (out_ready) begin
          state_nxt = lllt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lllt_pkg::ST_IDLE;
      end
    endcase
  end

  // control state and drive word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lllt_pkg::ST_IDLE;
      idx_r   <= '0;
      drive_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      drive_r <= drive_nxt;
    end
  end

  // command capture and result flags
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r   <= in_data.mode;
      bi_r     <= box_ok ? box_m1[IDX_W-1:0] : '0;
      slot_r   <= in_data.remap_slot[SLOT_W-1:0];
      box_ok_r <= box_ok;
      rej_r    <= rej;
    end
    light_on_r <= light_on_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_ticks_r  <= lllt_pkg::LOCK_TICKS_RST;
      light_ticks_r <= lllt_pkg::LIGHT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lllt_pkg::CFG_LOCK_TICKS:  lock_ticks_r  <= cfg_data[7:0];
        lllt_pkg::CFG_LIGHT_TICKS: light_ticks_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // per-box counts and slot map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BOX_COUNT; i++) begin
        lock_cnt_r[i]  <= 9'd0;
        light_cnt_r[i] <= 12'd0;
        slot_map_r[i]  <= SLOT_W'(i + 1);
      end
    end else begin
      if (lock_we) begin
        lock_cnt_r[idx_r] <= lock_wd;
      end
      if (light_we) begin
        light_cnt_r[idx_r] <= light_wd;
      end
      if (map_we) begin
        slot_map_r[idx_r] <= map_wd;
      end
    end
  end

endmodule
